// ----- hw/rtl/docb_pkg.sv -----
// ---------------------------------------------------------------------------
// docb_pkg: shared types and constants
// Types, codes and defaults used by the draw op cull batcher.
// ---------------------------------------------------------------------------
package docb_pkg;

  localparam int TEXTURE_SLOTS_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  localparam logic [1:0] STATUS_DRAWN   = 2'd0;
  localparam logic [1:0] STATUS_CULLED  = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [1:0] PIPE_TEXTURED = 2'd1;

  localparam logic [1:0] REG_VP_LEFT   = 2'd0;
  localparam logic [1:0] REG_VP_TOP    = 2'd1;
  localparam logic [1:0] REG_VP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_VP_BOTTOM = 2'd3;

  // classified op handed from front to back
  typedef struct packed {
    logic        frame_start;
    logic [1:0]  status;
    logic [63:0] scissor;
    logic [1:0]  pipe;
    logic [31:0] tex;
  } cls_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] inst_idx;
    logic [31:0] batch_index;
    logic        starts_batch;
    logic [63:0] scissor_rect;
    logic        texture_new;
    logic        texture_overflow;
    logic [31:0] culled_total;
  } res_t;

endpackage

// ----- hw/rtl/docb_if.sv -----
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for draw ops, results and register writes.
// ---------------------------------------------------------------------------
interface docb_in_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic [63:0] src_rect;
  logic [63:0] linear_part;
  logic [31:0] translation;
  logic        has_clip;
  logic [63:0] clip_rect;
  logic [1:0]  pipeline_kind;
  logic [31:0] texture_id;
  modport source(output valid, frame_start, src_rect, linear_part, translation,
                 has_clip, clip_rect, pipeline_kind, texture_id, input ready);
  modport sink(input valid, frame_start, src_rect, linear_part, translation,
               has_clip, clip_rect, pipeline_kind, texture_id, output ready);
endinterface

interface docb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] inst_idx;
  logic [31:0] batch_index;
  logic        starts_batch;
  logic [63:0] scissor_rect;
  logic        texture_new;
  logic        texture_overflow;
  logic [31:0] culled_total;
  modport source(output valid, status, inst_idx, batch_index, starts_batch,
                 scissor_rect, texture_new, texture_overflow, culled_total,
                 input ready);
  modport sink(input valid, status, inst_idx, batch_index, starts_batch,
               scissor_rect, texture_new, texture_overflow, culled_total,
               output ready);
endinterface

interface docb_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/docb_front.sv -----
// ---------------------------------------------------------------------------
// docb_front: transform and cull
// Maps the rect corners, bounds them, clips and builds the scissor.
// The corners are mapped in turn on two multiplier pairs (S_MAP), then the
// decision is registered (S_DEC) and handed off (S_OUT).
// ---------------------------------------------------------------------------
module docb_front #(
  parameter int COORD_BITS = docb_pkg::COORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  docb_in_if.sink         in_ch,
  input  logic [63:0]     viewport,
  output logic            q_valid,
  input  logic            q_ready,
  output docb_pkg::cls_t  q_data
);
  localparam int LB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam logic [2:0] S_IDLE = 3'd0, S_MAP = 3'd1, S_DEC = 3'd2, S_OUT = 3'd3;

  logic [2:0]  state_r;
  logic [1:0]  corner_r;
  logic [63:0] rect_r, mat_r, clip_r;
  logic [31:0] trans_r, tex_r;
  logic        has_clip_r, fs_r;
  logic [1:0]  pipe_r;
  logic signed [35:0] bl_r, br_r, bt_r, bb_r;
  docb_pkg::cls_t out_r;

  function automatic logic signed [16:0] lane(input logic [63:0] w, input int i);
    logic [15:0] v;
    logic signed [15:0] s;
    v = w[16*i +: 16];
    s = $signed(v << (16 - LB)) >>> (16 - LB);
    return 17'(s);
  endfunction

  function automatic logic signed [16:0] mx(input logic signed [16:0] a,
                                            input logic signed [16:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [16:0] mn(input logic signed [16:0] a,
                                            input logic signed [16:0] b);
    return (a < b) ? a : b;
  endfunction

  // corner products
  logic signed [16:0] cx, cy;
  logic signed [32:0] pxa, pxb, pya, pyb;
  logic signed [35:0] tx, ty;
  logic signed [35:0] px, py;
  always_comb begin
    cx = corner_r[0] ? lane(rect_r, 2) : lane(rect_r, 0);
    cy = corner_r[1] ? lane(rect_r, 3) : lane(rect_r, 1);
    pxa = $signed(mat_r[15:0]) * cx;
    pxb = $signed(mat_r[47:32]) * cy;
    pya = $signed(mat_r[31:16]) * cx;
    pyb = $signed(mat_r[63:48]) * cy;
    tx = 36'(lane({32'd0, trans_r}, 0)) <<< 12;
    ty = 36'(lane({32'd0, trans_r}, 1)) <<< 12;
    px = 36'(pxa) + 36'(pxb) + tx;
    py = 36'(pya) + 36'(pyb) + ty;
  end

  // clip and decision
  logic signed [16:0] vl, vt, vr, vb, cl, ct, cr, cb;
  logic signed [35:0] il, ir, it, ib;
  logic signed [16:0] sl, st, sr, sb;
  logic culled, vp_bad;
  always_comb begin
    vl = 17'($signed(viewport[15:0]));
    vt = 17'($signed(viewport[31:16]));
    vr = 17'($signed(viewport[47:32]));
    vb = 17'($signed(viewport[63:48]));
    vp_bad = (vr <= vl) || (vb <= vt);
    cl = vl; ct = vt; cr = vr; cb = vb;
    if (has_clip_r) begin
      cl = mx(vl, lane(clip_r, 0));
      ct = mx(vt, lane(clip_r, 1));
      cr = mn(vr, lane(clip_r, 2));
      cb = mn(vb, lane(clip_r, 3));
    end
    il = (bl_r > 36'(cl) <<< 12) ? bl_r : 36'(cl) <<< 12;
    ir = (br_r < 36'(cr) <<< 12) ? br_r : 36'(cr) <<< 12;
    it = (bt_r > 36'(ct) <<< 12) ? bt_r : 36'(ct) <<< 12;
    ib = (bb_r < 36'(cb) <<< 12) ? bb_r : 36'(cb) <<< 12;
    sl = cl >>> 4;
    st = ct >>> 4;
    sr = -((-cr) >>> 4);
    sb = -((-cb) >>> 4);
    culled = (cr <= cl) || (cb <= ct) || (ir <= il) || (ib <= it)
          || (sr <= sl) || (sb <= st);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign q_valid     = (state_r == S_OUT);
  assign q_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          state_r  <= S_MAP;
          corner_r <= 2'd0;
        end
        S_MAP: begin
          corner_r <= corner_r + 2'd1;
          if (corner_r == 2'd3) state_r <= S_DEC;
        end
        S_DEC: state_r <= S_OUT;
        S_OUT: if (q_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload capture and bound accumulation
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      rect_r     <= in_ch.src_rect;
      mat_r      <= in_ch.linear_part;
      trans_r    <= in_ch.translation;
      clip_r     <= in_ch.clip_rect;
      has_clip_r <= in_ch.has_clip;
      fs_r       <= in_ch.frame_start;
      pipe_r     <= in_ch.pipeline_kind;
      tex_r      <= in_ch.texture_id;
    end
    if (state_r == S_MAP) begin
      if (corner_r == 2'd0) begin
        bl_r <= px; br_r <= px; bt_r <= py; bb_r <= py;
      end else begin
        if (px < bl_r) bl_r <= px;
        if (px > br_r) br_r <= px;
        if (py < bt_r) bt_r <= py;
        if (py > bb_r) bb_r <= py;
      end
    end
    if (state_r == S_DEC) begin
      out_r.frame_start <= fs_r;
      out_r.status      <= vp_bad ? docb_pkg::STATUS_INVALID :
                           (culled ? docb_pkg::STATUS_CULLED : docb_pkg::STATUS_DRAWN);
      out_r.scissor     <= {sb[15:0], sr[15:0], st[15:0], sl[15:0]};
      out_r.pipe        <= pipe_r;
      out_r.tex         <= tex_r;
    end
  end
endmodule

// ----- hw/rtl/docb_queue.sv -----
// ---------------------------------------------------------------------------
// docb_queue: two-entry queue
// Decouples the classifier from the batch stage.
// ---------------------------------------------------------------------------
module docb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  docb_pkg::cls_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output docb_pkg::cls_t rd_data
);
  docb_pkg::cls_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- hw/rtl/docb_back.sv -----
// ---------------------------------------------------------------------------
// docb_back: batch and texture set
// Counts, batches and searches the texture set four slots a cycle.
// ---------------------------------------------------------------------------
module docb_back #(
  parameter int TEXTURE_SLOTS = docb_pkg::TEXTURE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  docb_pkg::cls_t q_data,
  docb_out_if.source     out_ch
);
  localparam int IW   = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
  localparam int NGRP = (TEXTURE_SLOTS + 3) / 4;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam logic [1:0] S_IDLE = 2'd0, S_SRCH = 2'd1, S_OUT = 2'd2;

  logic [1:0]  state_r;
  logic [31:0] inst_r, batch_r, cull_r;
  logic        bopen_r;
  logic [1:0]  bpipe_r;
  logic [31:0] btex_r;
  logic [63:0] bsc_r;
  logic [31:0] seen_r [TEXTURE_SLOTS];
  logic [TEXTURE_SLOTS-1:0] valid_r;
  logic [IW:0] fill_r;
  logic [GW-1:0] grp_r;
  logic        found_r;
  logic [31:0] tex_r;
  docb_pkg::res_t res_r;

  // four-slot compare
  logic hit;
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (int'(grp_r) * 4 + k < TEXTURE_SLOTS) begin
        if (valid_r[IW'(int'(grp_r) * 4 + k)] &&
            seen_r[IW'(int'(grp_r) * 4 + k)] == tex_r) hit = 1'b1;
      end
    end
  end

  assign q_ready      = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status           = res_r.status;
  assign out_ch.inst_idx         = res_r.inst_idx;
  assign out_ch.batch_index      = res_r.batch_index;
  assign out_ch.starts_batch     = res_r.starts_batch;
  assign out_ch.scissor_rect     = res_r.scissor_rect;
  assign out_ch.texture_new      = res_r.texture_new;
  assign out_ch.texture_overflow = res_r.texture_overflow;
  assign out_ch.culled_total     = res_r.culled_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      inst_r  <= '0; batch_r <= '0; cull_r <= '0;
      bopen_r <= 1'b0; bpipe_r <= '0; btex_r <= '0; bsc_r <= '0;
      valid_r <= '0; fill_r <= '0; grp_r <= '0; found_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          logic [31:0] inst_nxt, batch_nxt, cull_nxt;
          logic bopen_nxt, joins;
          logic [1:0] state_nxt;
          docb_pkg::res_t res_nxt;
          inst_nxt  = q_data.frame_start ? 32'd0 : inst_r;
          batch_nxt = q_data.frame_start ? 32'd0 : batch_r;
          cull_nxt  = q_data.frame_start ? 32'd0 : cull_r;
          bopen_nxt = q_data.frame_start ? 1'b0 : bopen_r;
          joins = bopen_nxt && bpipe_r == q_data.pipe && btex_r == q_data.tex &&
                  bsc_r == q_data.scissor;
          res_nxt = '0;
          res_nxt.status = q_data.status;
          state_nxt = S_OUT;
          if (q_data.status == docb_pkg::STATUS_CULLED) begin
            cull_nxt = cull_nxt + 32'd1;
          end else if (q_data.status == docb_pkg::STATUS_DRAWN) begin
            res_nxt.inst_idx     = inst_nxt;
            res_nxt.scissor_rect = q_data.scissor;
            inst_nxt = inst_nxt + 32'd1;
            if (joins) begin
              res_nxt.batch_index = batch_nxt - 32'd1;
            end else begin
              res_nxt.batch_index  = batch_nxt;
              res_nxt.starts_batch = 1'b1;
              batch_nxt = batch_nxt + 32'd1;
              bopen_nxt = 1'b1;
            end
            if (q_data.pipe == docb_pkg::PIPE_TEXTURED) state_nxt = S_SRCH;
          end
          res_nxt.culled_total = cull_nxt;
          // open a new batch, or drop the old one on frame start
          if (q_data.status == docb_pkg::STATUS_DRAWN && !joins) begin
            bpipe_r <= q_data.pipe; btex_r <= q_data.tex; bsc_r <= q_data.scissor;
          end else if (q_data.frame_start) begin
            bpipe_r <= '0; btex_r <= '0; bsc_r <= '0;
          end
          if (q_data.frame_start) begin
            valid_r <= '0; fill_r <= '0;
          end
          inst_r <= inst_nxt; batch_r <= batch_nxt; cull_r <= cull_nxt;
          bopen_r <= bopen_nxt;
          res_r <= res_nxt;
          tex_r <= q_data.tex;
          grp_r <= '0; found_r <= 1'b0;
          state_r <= state_nxt;
        end
        S_SRCH: begin
          if (hit || found_r) found_r <= 1'b1;
          grp_r <= grp_r + GW'(1);
          if (int'(grp_r) == NGRP - 1) begin
            state_r <= S_OUT;
            if (!(hit || found_r)) begin
              res_r.texture_new <= 1'b1;
              if (fill_r < (IW+1)'(TEXTURE_SLOTS)) begin
                valid_r[fill_r[IW-1:0]] <= 1'b1;
                fill_r <= fill_r + (IW+1)'(1);
              end else begin
                res_r.texture_overflow <= 1'b1;
              end
            end
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // texture store, filled in order
  always_ff @(posedge clk) begin
    if (state_r == S_SRCH && int'(grp_r) == NGRP - 1 && !(hit || found_r) &&
        fill_r < (IW+1)'(TEXTURE_SLOTS))
      seen_r[fill_r[IW-1:0]] <= tex_r;
  end
endmodule

// ----- hw/rtl/draw_op_cull_batcher.sv -----
// ---------------------------------------------------------------------------
// draw_op_cull_batcher: draw op cull and batch planner
// Transforms, clips and culls draw ops, then assigns instances and batches.
//
//  channel | dir | handshake
//  in_     | in  | in_.valid / in_.ready, one draw op
//  out_    | out | out_.valid / out_.ready, one result per op
//  cfg_    | in  | cfg_.valid / cfg_.ready, viewport register write
//
// Front: accept (S_IDLE), corners (S_MAP), decide (S_DEC), hand-off (S_OUT).
// Back: accept, search four slots at a time for drawn textured ops, result;
// with no stalls and the default TEXTURE_SLOTS the front sets the rate.
// A two-entry queue lets the front start the next op while the back works.
// Reset is synchronous, active low; the texture set is cleared by valid bits.
// A stalled out_ holds its result; the queue then fills and in_ stalls.
// ---------------------------------------------------------------------------
module draw_op_cull_batcher #(
  parameter int TEXTURE_SLOTS = docb_pkg::TEXTURE_SLOTS_DEF,
  parameter int COORD_BITS    = docb_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  docb_in_if.sink   in_,
  docb_out_if.source out_,
  docb_cfg_if.sink  cfg_
);
  logic [63:0] vp_r;
  logic q_wv, q_wr, q_rv, q_rr;
  docb_pkg::cls_t q_wd, q_rd;

  // viewport registers
  assign cfg_.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (cfg_.valid) begin
      case (cfg_.index)
        32'(docb_pkg::REG_VP_LEFT):   vp_r[15:0]  <= cfg_.data;
        32'(docb_pkg::REG_VP_TOP):    vp_r[31:16] <= cfg_.data;
        32'(docb_pkg::REG_VP_RIGHT):  vp_r[47:32] <= cfg_.data;
        32'(docb_pkg::REG_VP_BOTTOM): vp_r[63:48] <= cfg_.data;
        default: ;
      endcase
    end
  end

  docb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_ch(in_), .viewport(vp_r),
    .q_valid(q_wv), .q_ready(q_wr), .q_data(q_wd)
  );

  docb_queue u_queue (
    .clk, .rst_n, .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_wd),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_data(q_rd)
  );

  docb_back #(.TEXTURE_SLOTS(TEXTURE_SLOTS)) u_back (
    .clk, .rst_n, .q_valid(q_rv), .q_ready(q_rr), .q_data(q_rd), .out_ch(out_)
  );
endmodule

// ----- hw/rtl/docb_checker.sv -----
// ---------------------------------------------------------------------------
// docb_checker: port-level checks
// Watches result fields for consistency over time.
// ---------------------------------------------------------------------------
module docb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_starts_batch,
  input logic        out_texture_new,
  input logic        out_texture_overflow,
  input logic [31:0] out_inst_idx
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // overflow implies a new texture
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_texture_overflow |-> out_texture_new)
    else $error("overflow without new texture");

  // non-drawn results carry no batch info
  a_cull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != docb_pkg::STATUS_DRAWN |-> !out_starts_batch
      && !out_texture_new && out_inst_idx == 32'd0)
    else $error("culled result carries draw fields");

  // status is never the unused code
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= docb_pkg::STATUS_INVALID)
    else $error("bad status code");
endmodule

bind draw_op_cull_batcher docb_checker u_docb_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_.valid), .out_ready(out_.ready),
  .out_status(out_.status), .out_starts_batch(out_.starts_batch),
  .out_texture_new(out_.texture_new), .out_texture_overflow(out_.texture_overflow),
  .out_inst_idx(out_.inst_idx)
);

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb: draw op cull batcher testbench
// Drives draw ops and viewport writes, predicts each result and compares it.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        frame_start;
    logic [63:0] src_rect;
    logic [63:0] linear_part;
    logic [31:0] translation;
    logic        has_clip;
    logic [63:0] clip_rect;
    logic [1:0]  pipeline_kind;
    logic [31:0] texture_id;
  } op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  docb_in_if  op_ch();
  docb_out_if res_ch();
  docb_cfg_if cfg_ch();

  draw_op_cull_batcher u_top (
    .clk(clk), .rst_n(rst_n), .in_(op_ch.sink), .out_(res_ch.source), .cfg_(cfg_ch.sink)
  );

  op_t  pending_ops[$];
  docb_pkg::res_t expected_res[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   quiet_cycles = 0;

  // predictor state
  logic signed [15:0] vp_l, vp_t, vp_r, vp_b;
  logic [31:0] inst_cnt, batch_cnt, cull_cnt;
  logic        b_open;
  logic [1:0]  b_pipe;
  logic [31:0] b_tex;
  logic [63:0] b_sciss;
  logic [31:0] tex_set[16];
  logic [15:0] tex_valid;

  function automatic void clear_frame_state();
    inst_cnt = 0; batch_cnt = 0; cull_cnt = 0;
    b_open = 0; b_pipe = 0; b_tex = 0; b_sciss = 0; tex_valid = 0;
  endfunction

  function automatic void add_op(op_t op);
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  function automatic longint ln(logic [63:0] w, int i);
    logic signed [15:0] v;
    v = w[16*i +: 16];
    return longint'(v);
  endfunction

  function automatic longint fl16(longint v);
    return v >>> 4;
  endfunction

  // compute the result an op should produce and advance state
  function automatic docb_pkg::res_t predict_result(op_t op);
    docb_pkg::res_t r;
    longint cl, ct, cr, cb, px, py, bl, bt, br, bb, sl, st, sr, sb;
    longint lx[2], ly[2], m11, m12, m21, m22, dx, dy;
    bit cul, found;
    int fs;
    logic [63:0] sc;
    r = '0;
    if (op.frame_start) clear_frame_state();
    if (vp_r <= vp_l || vp_b <= vp_t) begin
      r.status = docb_pkg::STATUS_INVALID;
      r.culled_total = cull_cnt;
      return r;
    end
    cl = vp_l; ct = vp_t; cr = vp_r; cb = vp_b;
    if (op.has_clip) begin
      if (ln(op.clip_rect, 0) > cl) cl = ln(op.clip_rect, 0);
      if (ln(op.clip_rect, 1) > ct) ct = ln(op.clip_rect, 1);
      if (ln(op.clip_rect, 2) < cr) cr = ln(op.clip_rect, 2);
      if (ln(op.clip_rect, 3) < cb) cb = ln(op.clip_rect, 3);
    end
    lx[0] = ln(op.src_rect, 0); ly[0] = ln(op.src_rect, 1);
    lx[1] = ln(op.src_rect, 2); ly[1] = ln(op.src_rect, 3);
    m11 = ln(op.linear_part, 0); m12 = ln(op.linear_part, 1);
    m21 = ln(op.linear_part, 2); m22 = ln(op.linear_part, 3);
    dx = ln({32'd0, op.translation}, 0) * 4096;
    dy = ln({32'd0, op.translation}, 1) * 4096;
    for (int i = 0; i < 4; i++) begin
      px = m11 * lx[i & 1] + m21 * ly[i >> 1] + dx;
      py = m12 * lx[i & 1] + m22 * ly[i >> 1] + dy;
      if (i == 0) begin
        bl = px; br = px; bt = py; bb = py;
      end else begin
        if (px < bl) bl = px;
        if (px > br) br = px;
        if (py < bt) bt = py;
        if (py > bb) bb = py;
      end
    end
    cul = (cr <= cl) || (cb <= ct);
    if (!cul) begin
      if (cl * 4096 > bl) bl = cl * 4096;
      if (cr * 4096 < br) br = cr * 4096;
      if (ct * 4096 > bt) bt = ct * 4096;
      if (cb * 4096 < bb) bb = cb * 4096;
      cul = (br <= bl) || (bb <= bt);
    end
    sl = fl16(cl); st = fl16(ct); sr = -fl16(-cr); sb = -fl16(-cb);
    if (!cul && (sr <= sl || sb <= st)) cul = 1;
    if (cul) begin
      cull_cnt++;
      r.status = docb_pkg::STATUS_CULLED;
      r.culled_total = cull_cnt;
      return r;
    end
    sc = {sb[15:0], sr[15:0], st[15:0], sl[15:0]};
    r.status = docb_pkg::STATUS_DRAWN;
    r.inst_idx = inst_cnt;
    inst_cnt++;
    if (b_open && b_pipe == op.pipeline_kind && b_tex == op.texture_id && b_sciss == sc) begin
      r.batch_index = batch_cnt - 1;
    end else begin
      r.batch_index = batch_cnt;
      r.starts_batch = 1;
      batch_cnt++;
      b_open = 1; b_pipe = op.pipeline_kind; b_tex = op.texture_id; b_sciss = sc;
    end
    r.scissor_rect = sc;
    if (op.pipeline_kind == docb_pkg::PIPE_TEXTURED) begin
      found = 0; fs = 16;
      for (int i = 0; i < 16; i++) begin
        if (tex_valid[i]) begin
          if (tex_set[i] == op.texture_id) found = 1;
        end else if (fs == 16) fs = i;
      end
      if (!found) begin
        r.texture_new = 1;
        if (fs < 16) begin
          tex_set[fs] = op.texture_id;
          tex_valid[fs] = 1;
        end else r.texture_overflow = 1;
      end
    end
    r.culled_total = cull_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // driver: present pending ops
  always @(posedge clk) begin
    if (!rst_n) begin
      op_ch.valid <= 1'b0;
    end else if (!op_ch.valid || op_ch.ready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op_t op;
        op = pending_ops.pop_front();
        expected_res.insert(expected_res.size(), predict_result(op));
        op_ch.valid <= 1'b1;
        op_ch.frame_start <= op.frame_start;
        op_ch.src_rect <= op.src_rect;
        op_ch.linear_part <= op.linear_part;
        op_ch.translation <= op.translation;
        op_ch.has_clip <= op.has_clip;
        op_ch.clip_rect <= op.clip_rect;
        op_ch.pipeline_kind <= op.pipeline_kind;
        op_ch.texture_id <= op.texture_id;
      end else begin
        op_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compare results and toggle ready
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", res_ch.status, 0);
        end else begin
          docb_pkg::res_t e;
          e = expected_res.pop_front();
          if (res_ch.status !== e.status) report_mismatch("status", res_ch.status, e.status);
          if (res_ch.inst_idx !== e.inst_idx)
            report_mismatch("inst_idx", res_ch.inst_idx, e.inst_idx);
          if (res_ch.batch_index !== e.batch_index)
            report_mismatch("batch_index", res_ch.batch_index, e.batch_index);
          if (res_ch.starts_batch !== e.starts_batch)
            report_mismatch("starts_batch", res_ch.starts_batch, e.starts_batch);
          if (res_ch.scissor_rect !== e.scissor_rect)
            report_mismatch("scissor_rect", res_ch.scissor_rect, e.scissor_rect);
          if (res_ch.texture_new !== e.texture_new)
            report_mismatch("texture_new", res_ch.texture_new, e.texture_new);
          if (res_ch.texture_overflow !== e.texture_overflow)
            report_mismatch("texture_overflow", res_ch.texture_overflow, e.texture_overflow);
          if (res_ch.culled_total !== e.culled_total)
            report_mismatch("culled_total", res_ch.culled_total, e.culled_total);
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: count cycles without any request moving
  always @(posedge clk) begin
    if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= 32'(idx);
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      docb_pkg::REG_VP_LEFT:   vp_l = val;
      docb_pkg::REG_VP_TOP:    vp_t = val;
      docb_pkg::REG_VP_RIGHT:  vp_r = val;
      default:                 vp_b = val;
    endcase
  endtask

  task automatic set_viewport(logic [15:0] l, logic [15:0] t, logic [15:0] r, logic [15:0] b);
    write_reg(docb_pkg::REG_VP_LEFT, l);
    write_reg(docb_pkg::REG_VP_TOP, t);
    write_reg(docb_pkg::REG_VP_RIGHT, r);
    write_reg(docb_pkg::REG_VP_BOTTOM, b);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || expected_res.size() > 0 || op_ch.valid) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(int span);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  // mostly well-formed op: moderate rect, near-axis matrix, small texture pool; one in ten fully random
  function automatic op_t rand_op();
    op_t op;
    logic [15:0] l, t;
    op.frame_start = ($urandom_range(39) == 0);
    if ($urandom_range(9) == 0) begin
      op.src_rect = {$urandom, $urandom};
      op.linear_part = {$urandom, $urandom};
      op.translation = $urandom;
      op.clip_rect = {$urandom, $urandom};
    end else begin
      l = rnd_coord(2000); t = rnd_coord(2000);
      op.src_rect = {t + 16'($urandom_range(800)), l + 16'($urandom_range(800)), t, l};
      op.linear_part = {16'(4096 + $urandom_range(512) - 256), rnd_coord(300),
                        rnd_coord(300), 16'(4096 + $urandom_range(512) - 256)};
      op.translation = {rnd_coord(1500), rnd_coord(1500)};
      l = rnd_coord(1500); t = rnd_coord(1500);
      op.clip_rect = ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                     {t + 16'($urandom_range(1200)), l + 16'($urandom_range(1200)), t, l};
    end
    op.has_clip = 1'($urandom_range(1));
    op.pipeline_kind = 2'($urandom_range(3));
    if ($urandom_range(1)) op.pipeline_kind = docb_pkg::PIPE_TEXTURED;
    op.texture_id = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(23));
    return op;
  endfunction

  function automatic op_t mk_op(logic fs, logic [63:0] lr, logic [63:0] lp, logic [31:0] tr,
                                logic hc, logic [63:0] cr, logic [1:0] pk, logic [31:0] tx);
    op_t op;
    op.frame_start = fs; op.src_rect = lr; op.linear_part = lp; op.translation = tr;
    op.has_clip = hc; op.clip_rect = cr; op.pipeline_kind = pk; op.texture_id = tx;
    return op;
  endfunction

  localparam logic [63:0] IDENT = {16'h1000, 16'h0000, 16'h0000, 16'h1000};
  localparam logic [63:0] BOX = {16'd320, 16'd320, 16'd16, 16'd16};

  initial begin
    op_ch.valid = 0; op_ch.frame_start = 0; op_ch.src_rect = 0; op_ch.linear_part = 0;
    op_ch.translation = 0; op_ch.has_clip = 0; op_ch.clip_rect = 0;
    op_ch.pipeline_kind = 0; op_ch.texture_id = 0;
    res_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    vp_l = 0; vp_t = 0; vp_r = 0; vp_b = 0;
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset viewport is empty: invalid status, frame start still clears
    add_op(mk_op(1, BOX, IDENT, 0, 0, 0, 0, 0));
    add_op(mk_op(0, BOX, IDENT, 0, 1, BOX, 1, 5));
    drain();

    set_viewport(16'd0, 16'd0, 16'd1024, 16'd768);
    // drawn, joined batch, new batch, culled outside, empty clip, extremes, mirror, full set
    add_op(mk_op(1, BOX, IDENT, 0, 0, 0, 1, 7));
    add_op(mk_op(0, BOX, IDENT, 0, 0, 0, 1, 7));
    add_op(mk_op(0, BOX, IDENT, 0, 1, {16'd407, 16'd407, 16'd9, 16'd9}, 0, 7));
    add_op(mk_op(0, BOX, IDENT, {16'd30000, 16'd30000}, 0, 0, 2, 0));
    add_op(mk_op(0, BOX, IDENT, 0, 1, {16'd50, 16'd50, 16'd60, 16'd60}, 3, 0));
    add_op(mk_op(0, 64'h7FFF7FFF80008000, 64'hFFFF8000_7FFF8000,
                 32'h80007FFF, 1, 64'h7FFF7FFF80008000, 3, 32'hFFFFFFFF));
    add_op(mk_op(0, BOX, 64'h8000_0000_0000_8000, 0, 0, 0, 0, 0));
    for (int i = 0; i < 18; i++)
      add_op(mk_op(0, BOX, IDENT, 0, 0, 0, docb_pkg::PIPE_TEXTURED, 32'(100 + i)));
    drain();

    // random phases across viewport settings and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_viewport(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        1: set_viewport(16'd0, 16'd0, 16'd8000, 16'd6000);
        2: set_viewport(rnd_coord(3000), rnd_coord(3000), rnd_coord(3000), rnd_coord(3000));
        default: set_viewport(-16'd1000, -16'd800, 16'd1013, 16'd777);
      endcase
      send_idle_pct = (ph < 3) ? 19 : (ph < 6) ? 53 : 0;
      recv_idle_pct = (ph < 3) ? 53 : (ph < 6) ? 19 : 0;
      for (int i = 0; i < 100; i++) add_op(rand_op());
      drain();
    end

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/docb_pkg.sv
hw/rtl/docb_if.sv
hw/rtl/docb_front.sv
hw/rtl/docb_queue.sv
hw/rtl/docb_back.sv
hw/rtl/draw_op_cull_batcher.sv
hw/rtl/docb_checker.sv
tb/tb.sv
